/* rtl/hcpa_pkg.sv */
// ----------------------------------------------------------------------------
// Harmonic chord profile accumulator package
// Shared widths, codes, harmonic tables and control types.
// ----------------------------------------------------------------------------
package hcpa_pkg;

    localparam int BIN_COUNT        = 12;
    localparam int BIN_IW           = 4;
    localparam int BIN_W            = 40;
    localparam int AMT_W            = 32;
    localparam int PITCH_W          = 4;
    localparam int COUNT_W          = 5;
    localparam int DECAY_W          = 17;
    localparam int SHARE_W          = 17;
    localparam int PROD_W           = AMT_W + SHARE_W;
    localparam int FRAC_W           = 16;
    localparam int ROM_DEPTH        = 64;
    localparam int ROM_AW           = 6;
    localparam int MAX_HARMONICS_DEF = 16;

    localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(65536);

    localparam logic [BIN_IW-1:0] THIRD_MAJOR = BIN_IW'(4);
    localparam logic [BIN_IW-1:0] THIRD_MINOR = BIN_IW'(3);
    localparam logic [BIN_IW-1:0] FIFTH       = BIN_IW'(7);
    localparam logic [BIN_IW-1:0] LAST_CLASS  = BIN_IW'(11);

    localparam int CFG_AW = 1;
    localparam int CFG_DW = DECAY_W;
    localparam logic [CFG_AW-1:0] REG_HARMONIC_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] REG_HARMONIC_DECAY = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_MAJOR = 2'd2,
        CMD_MINOR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOTE_START,
        ST_HARM,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              note_start;
        logic [1:0]        note_sel;
        logic              step;
        logic [ROM_AW-1:0] harm_idx;
        logic              snap;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t               item_cmd;
        logic [COUNT_W-1:0] harm_count;
    } dp_status_t;

    // Semitone offset mod 12 of each harmonic above the note.
    localparam logic [BIN_IW-1:0] HARM_OFFSET [ROM_DEPTH] = '{
        4'd0, 4'd0, 4'd7, 4'd0, 4'd3, 4'd7, 4'd9, 4'd0,
        4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd9, 4'd10, 4'd0,
        4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd7, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd0,
        4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7,
        4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9,
        4'd9, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd0
    };

    // Share of the weight that stays in the lower class, Q1.16.
    localparam logic [SHARE_W-1:0] HARM_LOW_SHARE [ROM_DEPTH] = '{
        17'd65536, 17'd65536, 17'd65474, 17'd65536,
        17'd2983,  17'd65474, 17'd14498, 17'd65536,
        17'd65289, 17'd2983,  17'd31412, 17'd65474,
        17'd42376, 17'd14498, 17'd2200,  17'd65536,
        17'd65140, 17'd65289, 17'd100,   17'd2983,
        17'd12863, 17'd31412, 17'd53437, 17'd65474,
        17'd11387, 17'd42376, 17'd64981, 17'd14498,
        17'd52379, 17'd2200,  17'd37858, 17'd65536,
        17'd29405, 17'd65140, 17'd27500, 17'd65289,
        17'd31385, 17'd100,   17'd40435, 17'd2983,
        17'd52801, 17'd12863, 17'd63414, 17'd31412,
        17'd1533,  17'd53437, 17'd17429, 17'd65474,
        17'd45163, 17'd11387, 17'd64767, 17'd42376,
        17'd10711, 17'd64981, 17'd45182, 17'd14498,
        17'd5,     17'd52379, 17'd23456, 17'd2200,
        17'd61033, 17'd37858, 17'd11303, 17'd65536
    };

endpackage

/* rtl/hcpa_if.sv */
// ----------------------------------------------------------------------------
// Harmonic chord profile accumulator channels
// Valid/ready channels for input items and for profile results.
// ----------------------------------------------------------------------------
interface hcpa_item_if import hcpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [PITCH_W-1:0] pitch;
    logic [AMT_W-1:0]   amount;

    modport source (output valid, output cmd, output pitch, output amount, input ready);
    modport sink   (input valid, input cmd, input pitch, input amount, output ready);
endinterface

interface hcpa_result_if import hcpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] bin_c;
    logic [BIN_W-1:0] bin_cs;
    logic [BIN_W-1:0] bin_d;
    logic [BIN_W-1:0] bin_ds;
    logic [BIN_W-1:0] bin_e;
    logic [BIN_W-1:0] bin_f;
    logic [BIN_W-1:0] bin_fs;
    logic [BIN_W-1:0] bin_g;
    logic [BIN_W-1:0] bin_gs;
    logic [BIN_W-1:0] bin_a;
    logic [BIN_W-1:0] bin_as;
    logic [BIN_W-1:0] bin_b;

    modport source (
        output valid, input ready,
        output bin_c, output bin_cs, output bin_d, output bin_ds, output bin_e, output bin_f,
        output bin_fs, output bin_g, output bin_gs, output bin_a, output bin_as, output bin_b
    );
    modport sink (
        input valid, output ready,
        input bin_c, input bin_cs, input bin_d, input bin_ds, input bin_e, input bin_f,
        input bin_fs, input bin_g, input bin_gs, input bin_a, input bin_as, input bin_b
    );
endinterface

/* rtl/harmonic_chord_profile_accumulator.sv */
// ----------------------------------------------------------------------------
// Harmonic chord profile accumulator
// Twelve saturating pitch-class bins fed with harmonically weighted notes
// and triads; the whole profile is returned after every item.
// ----------------------------------------------------------------------------
// Usage: items arrive on the item channel (cmd, pitch, amount) and one
// profile beat per item leaves on the result channel with all twelve bins.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata while the block is idle.
// A clear goes from accept straight to the finish state; a single note or a
// triad runs, for each chord tone, a note start and n harmonic steps, then a
// drain state, where n is the harmonic count limited to MAX_HARMONICS. The
// next item is taken once the controller returns to idle after the result
// is loaded. The one weighting unit handles one harmonic per cycle: a table
// lookup and two 32x17 products, then a saturating add into the bins in the
// next cycle.
// Results sit in an output register; a new item is accepted while a result
// waits, and a finished profile waits in place until that register frees.
// Reset clears the bins and the handshakes and sets the harmonic count to 4
// and the decay to 39322 (about 0.6).
// ----------------------------------------------------------------------------
module harmonic_chord_profile_accumulator import hcpa_pkg::*;
#(
    parameter int MAX_HARMONICS = MAX_HARMONICS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    hcpa_item_if.sink         item,
    hcpa_result_if.source     result
);

    ctrl_cmd_t        ctl;
    dp_status_t       status;
    logic [BIN_W-1:0] snap_bins [BIN_COUNT];

    hcpa_ctrl #(
        .MAX_HARMONICS (MAX_HARMONICS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_cmd     (cmd_t'(item.cmd)),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .ctl          (ctl)
    );

    hcpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (item.cmd),
        .in_pitch  (item.pitch),
        .in_amount (item.amount),
        .ctl       (ctl),
        .status    (status),
        .snap_bins (snap_bins)
    );

    assign result.bin_c  = snap_bins[0];
    assign result.bin_cs = snap_bins[1];
    assign result.bin_d  = snap_bins[2];
    assign result.bin_ds = snap_bins[3];
    assign result.bin_e  = snap_bins[4];
    assign result.bin_f  = snap_bins[5];
    assign result.bin_fs = snap_bins[6];
    assign result.bin_g  = snap_bins[7];
    assign result.bin_gs = snap_bins[8];
    assign result.bin_a  = snap_bins[9];
    assign result.bin_as = snap_bins[10];
    assign result.bin_b  = snap_bins[11];

endmodule

/* rtl/hcpa_datapath.sv */
// ----------------------------------------------------------------------------
// Harmonic chord profile accumulator datapath
// Item and configuration registers, two-stage harmonic weighting pipe,
// the twelve saturating class bins and the result snapshot.
// ----------------------------------------------------------------------------
module hcpa_datapath import hcpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  logic [1:0]          in_cmd,
    input  logic [PITCH_W-1:0]  in_pitch,
    input  logic [AMT_W-1:0]    in_amount,
    input  ctrl_cmd_t           ctl,
    output dp_status_t          status,
    output logic [BIN_W-1:0]    snap_bins [BIN_COUNT]
);

    logic [COUNT_W-1:0] count_reg;
    logic [DECAY_W-1:0] decay_reg;

    cmd_t               cmd_reg;
    logic [BIN_IW-1:0]  root_reg;
    logic [AMT_W-1:0]   amount_reg;

    logic [BIN_IW-1:0]  pc_reg;
    logic [AMT_W-1:0]   w_reg;

    logic               s1_valid_reg;
    logic [BIN_IW-1:0]  s1_lo_reg;
    logic [AMT_W-1:0]   s1_w_reg;
    logic [AMT_W-1:0]   s1_low_reg;

    logic [BIN_W-1:0]   bins_reg  [BIN_COUNT];
    logic [BIN_W-1:0]   bins_next [BIN_COUNT];

    logic [BIN_IW-1:0]  root_in;
    logic [BIN_IW-1:0]  third_off;
    logic [BIN_IW:0]    note_sum;
    logic [BIN_IW-1:0]  note_pc;
    logic [BIN_IW:0]    lo_sum;
    logic [BIN_IW-1:0]  lo_idx;
    logic [DECAY_W-1:0] slope;
    logic [PROD_W-1:0]  prod_low;
    logic [PROD_W-1:0]  prod_w;

    logic               wrap;
    logic [BIN_IW-1:0]  hi_idx;
    logic [AMT_W-1:0]   add_lo;
    logic [AMT_W-1:0]   add_hi;
    logic [AMT_W-1:0]   add_amt [BIN_COUNT];
    logic [BIN_W:0]     add_sum [BIN_COUNT];

    assign status.item_cmd   = cmd_reg;
    assign status.harm_count = count_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(4);
            decay_reg <= DECAY_W'(39322);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_HARMONIC_COUNT: count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_HARMONIC_DECAY: decay_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pitch classes 12..15 fold back into the octave.
    assign root_in = (in_pitch >= PITCH_W'(BIN_COUNT)) ? in_pitch - PITCH_W'(BIN_COUNT)
                                                       : in_pitch;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd_t'(in_cmd);
            root_reg   <= root_in;
            amount_reg <= in_amount;
        end
    end

    // Pitch class of the current chord tone.
    always_comb
    begin
        third_off = (cmd_reg == CMD_MAJOR) ? THIRD_MAJOR : THIRD_MINOR;
        case (ctl.note_sel)
            2'd1:    note_sum = {1'b0, root_reg} + {1'b0, third_off};
            2'd2:    note_sum = {1'b0, root_reg} + {1'b0, FIFTH};
            default: note_sum = {1'b0, root_reg};
        endcase
        note_pc = (note_sum >= (BIN_IW+1)'(BIN_COUNT))
                  ? BIN_IW'(note_sum - (BIN_IW+1)'(BIN_COUNT)) : note_sum[BIN_IW-1:0];
    end

    // Stage one: table lookup, lower share and decayed weight.
    assign lo_sum   = {1'b0, pc_reg} + {1'b0, HARM_OFFSET[ctl.harm_idx]};
    assign lo_idx   = (lo_sum >= (BIN_IW+1)'(BIN_COUNT))
                      ? BIN_IW'(lo_sum - (BIN_IW+1)'(BIN_COUNT)) : lo_sum[BIN_IW-1:0];
    assign slope    = (decay_reg > DECAY_ONE) ? DECAY_ONE : decay_reg;
    assign prod_low = PROD_W'(w_reg) * PROD_W'(HARM_LOW_SHARE[ctl.harm_idx]);
    assign prod_w   = PROD_W'(w_reg) * PROD_W'(slope);

    always_ff @(posedge clk)
    begin
        if (ctl.note_start)
        begin
            pc_reg <= note_pc;
            w_reg  <= amount_reg;
        end
        else if (ctl.step)
        begin
            w_reg <= prod_w[FRAC_W+AMT_W-1:FRAC_W];
        end
        if (ctl.step)
        begin
            s1_lo_reg  <= lo_idx;
            s1_w_reg   <= w_reg;
            s1_low_reg <= prod_low[FRAC_W+AMT_W-1:FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= ctl.step;
    end

    // Stage two: split the weight over two neighbor classes. When the lower
    // class is the last one, the whole weight stays there.
    assign wrap   = (s1_lo_reg == LAST_CLASS);
    assign hi_idx = wrap ? '0 : s1_lo_reg + BIN_IW'(1);
    assign add_lo = wrap ? s1_w_reg : s1_low_reg;
    assign add_hi = s1_w_reg - s1_low_reg;

    always_comb
    begin
        for (int i = 0; i < BIN_COUNT; i++)
        begin
            add_amt[i] = '0;
            if (s1_valid_reg)
            begin
                if (s1_lo_reg == BIN_IW'(i))
                    add_amt[i] = add_lo;
                else if (!wrap && hi_idx == BIN_IW'(i))
                    add_amt[i] = add_hi;
            end
            add_sum[i]   = {1'b0, bins_reg[i]} + (BIN_W+1)'(add_amt[i]);
            bins_next[i] = add_sum[i][BIN_W] ? {BIN_W{1'b1}} : add_sum[i][BIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
                bins_reg[i] <= '0;
        end
        else if (ctl.load && cmd_t'(in_cmd) == CMD_CLEAR)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
                bins_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < BIN_COUNT; i++)
                bins_reg[i] <= bins_next[i];
        end
    end

    // Result register, loaded once the profile is final.
    always_ff @(posedge clk)
    begin
        if (ctl.snap)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
                snap_bins[i] <= bins_reg[i];
        end
    end

endmodule

/* rtl/hcpa_ctrl.sv */
// ----------------------------------------------------------------------------
// Harmonic chord profile accumulator controller
// Sequences chord tones and harmonics and owns the channel handshakes.
// ----------------------------------------------------------------------------
module hcpa_ctrl import hcpa_pkg::*;
#(
    parameter int MAX_HARMONICS = MAX_HARMONICS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  cmd_t       item_cmd,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctl
);

    localparam int CW = $clog2(MAX_HARMONICS + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    state_t            state_reg;
    state_t            state_next;
    logic [1:0]        note_reg;
    logic [1:0]        note_next;
    logic [CW-1:0]     harm_reg;
    logic [CW-1:0]     harm_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [LW-1:0]     count_ext;
    logic [LW-1:0]     limit_ext;
    logic [CW-1:0]     limit;
    logic [1:0]        last_note;
    logic              harm_more;
    logic              can_snap;
    logic [CW+ROM_AW-1:0] harm_ext;

    assign count_ext = LW'(status.harm_count);
    assign limit_ext = (count_ext > LW'(MAX_HARMONICS)) ? LW'(MAX_HARMONICS) : count_ext;
    assign limit     = limit_ext[CW-1:0];
    assign last_note = (status.item_cmd == CMD_NOTE) ? 2'd0 : 2'd2;
    assign harm_more = (harm_reg < limit);
    assign can_snap  = !out_valid_reg || result_ready;
    assign harm_ext  = (CW+ROM_AW)'(harm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            note_reg      <= '0;
            harm_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            note_reg      <= note_next;
            harm_reg      <= harm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        note_next  = note_reg;
        harm_next  = harm_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    note_next  = '0;
                    state_next = (item_cmd == CMD_CLEAR) ? ST_FINISH : ST_NOTE_START;
                end
            end
            ST_NOTE_START:
            begin
                harm_next  = '0;
                state_next = ST_HARM;
            end
            ST_HARM:
            begin
                if (harm_more)
                    harm_next = harm_reg + CW'(1);
                else if (note_reg != last_note)
                begin
                    note_next  = note_reg + 2'd1;
                    state_next = ST_NOTE_START;
                end
                else
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (can_snap)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs to the datapath and the channels.
    always_comb
    begin
        ctl            = '0;
        ctl.note_sel   = note_reg;
        ctl.harm_idx   = harm_ext[ROM_AW-1:0];
        item_ready     = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                ctl.load   = item_valid;
            end
            ST_NOTE_START:
                ctl.note_start = 1'b1;
            ST_HARM:
                ctl.step = harm_more;
            ST_DRAIN: ;
            ST_FINISH:
            begin
                if (can_snap)
                begin
                    ctl.snap       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule
